// ===== design/bfsa_pkg.sv =====
// Shared types and constants for the best-fit segment allocator.
`default_nettype none
package bfsa_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int ID_BITS      = 16;
   localparam int FIELD_W      = 21;
   localparam int OID_W        = 16;

   localparam logic [FIELD_W-1:0] POOL_RESET = 21'd1024;
   localparam logic [FIELD_W-1:0] POOL_LIMIT = 21'd1048576;

   // entry layout: start, size, used, id (lowest first)
   localparam int START_LSB = 0;
   localparam int SIZE_LSB  = FIELD_W;
   localparam int USED_BIT  = 2 * FIELD_W;
   localparam int ID_LSB    = 2 * FIELD_W + 1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_COMPACT = 2'd2,
      OP_INIT    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_BAD_SIZE      = 3'd1,
      ST_NO_FIT        = 3'd2,
      ST_UNKNOWN_ID    = 3'd3,
      ST_TABLE_FULL    = 3'd4,
      ST_IDS_EXHAUSTED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SH_HOLD   = 2'd0,
      SH_LEFT   = 2'd1,
      SH_INSERT = 2'd2,
      SH_REMOVE = 2'd3
   } shift_mode_type;

   typedef struct packed {
      shift_mode_type mode;
      logic           wr_en;
   } cell_ctl_type;

   typedef enum logic [3:0] {
      S_BOOT    = 4'd0,
      S_IDLE    = 4'd1,
      S_SCAN    = 4'd2,
      S_DECIDE  = 4'd3,
      S_INS     = 4'd4,
      S_WR      = 4'd5,
      S_REM_A   = 4'd6,
      S_REM_B   = 4'd7,
      S_COMPACT = 4'd8,
      S_DONE    = 4'd9
   } state_type;

endpackage
`default_nettype wire

// ===== design/bfsa_cell.sv =====
// One table cell: holds a segment entry and trades it with its neighbors.
`default_nettype none
module bfsa_cell #(
   parameter int IDX  = 0,
   parameter int IDXW = 6,
   parameter int ENTW = 59
) (
   input  wire                        clock,
   input  bfsa_pkg::cell_ctl_type     ctl,
   input  wire [IDXW-1:0]             sel_idx,
   input  wire [IDXW-1:0]             wr_idx,
   input  wire [ENTW-1:0]             wr_data,
   input  wire [ENTW-1:0]             left_q,
   input  wire [ENTW-1:0]             right_q,
   output logic [ENTW-1:0]            q
);

   localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

   logic [ENTW-1:0] entry_ff;
   logic [ENTW-1:0] entry_in;

   // direct write wins over any shift
   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr_en && wr_idx == MY_IDX) begin
         entry_in = wr_data;
      end else begin
         case (ctl.mode)
            bfsa_pkg::SH_LEFT:   entry_in = right_q;
            bfsa_pkg::SH_INSERT: entry_in = (MY_IDX > sel_idx) ? left_q : entry_ff;
            bfsa_pkg::SH_REMOVE: entry_in = (MY_IDX >= sel_idx) ? right_q : entry_ff;
            default:             entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

// ===== design/best_fit_segment_allocator.sv =====
// Top level: segment table as a ring of cells plus the operation sequencer.
// Allocate and free make one pass over the cell ring, and each pass rotates
// the ring once; compact makes a second pass unless every entry is used, while
// init and a rejected allocate make no pass. One transaction is worked on at
// a time; the next is accepted as soon as the result sits in the output register.
// Reset (synchronous): the boot state writes a single free segment of 1024.
`default_nettype none
module best_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS,
   parameter int ID_BITS      = bfsa_pkg::ID_BITS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // request_size[20:0], owner_id[36:21], zero pad
   input  wire  [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // granted_id[15:0], segment_start[36:16],
                                    // segment_size[57:37], zero pad
   output logic [2:0]  rsp_tuser,   // status[2:0]
   input  wire         csr_wr_en,
   input  wire  [20:0] csr_wr_data  // pool_size
);

   localparam int FW   = bfsa_pkg::FIELD_W;
   localparam int IDXW = $clog2(MAX_SEGMENTS);
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int ENTW = bfsa_pkg::ID_LSB + ID_BITS;
   localparam int CMPW = (ID_BITS > bfsa_pkg::OID_W) ? ID_BITS : bfsa_pkg::OID_W;
   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_SEGMENTS);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_SEGMENTS - 1);

   // ---------------- cell ring ----------------
   logic [ENTW-1:0]        cell_q [MAX_SEGMENTS];
   bfsa_pkg::cell_ctl_type ctl;
   logic [IDXW-1:0]        sel_idx;
   logic [IDXW-1:0]        wr_idx;
   logic [ENTW-1:0]        wr_data;

   for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      bfsa_cell #(.IDX(g), .IDXW(IDXW), .ENTW(ENTW)) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .sel_idx (sel_idx),
         .wr_idx  (wr_idx),
         .wr_data (wr_data),
         .left_q  (cell_q[(g + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
         .right_q (cell_q[(g + 1) % MAX_SEGMENTS]),
         .q       (cell_q[g])
      );
   end

   // ---------------- registers ----------------
   bfsa_pkg::state_type  state_ff, state_in;
   logic [FW-1:0]        pool_ff;
   logic [CNTW-1:0]      count_ff;
   logic [ID_BITS:0]     next_id_ff;
   logic                 rsp_valid_ff;

   bfsa_pkg::op_type     op_ff;
   logic [FW-1:0]        req_ff;
   logic [15:0]          oid_ff;
   logic [IDXW-1:0]      t_ff;
   logic                 found_ff;
   logic [IDXW-1:0]      b_idx_ff;
   logic [FW-1:0]        b_start_ff, b_size_ff;
   logic                 p_free_ff, n_free_ff, after_ff;
   logic [FW-1:0]        p_start_ff, p_size_ff, n_size_ff;
   logic                 prev_used_ff;
   logic [FW-1:0]        prev_start_ff, prev_size_ff;
   logic [FW-1:0]        total_ff, nxt_ff;
   logic [CNTW-1:0]      nused_ff, w_ff;
   logic [IDXW-1:0]      w_idx_ff;
   logic [ENTW-1:0]      wr_data_ff;

   bfsa_pkg::status_type res_status_ff, rsp_status_ff;
   logic [15:0]          res_gid_ff, rsp_gid_ff;
   logic [FW-1:0]        res_start_ff, rsp_start_ff;
   logic [FW-1:0]        res_size_ff, rsp_size_ff;

   // ---------------- decode ----------------
   bfsa_pkg::op_type in_op;
   logic [FW-1:0]    in_req;
   logic [15:0]      in_oid;
   logic             accept;
   assign in_op  = bfsa_pkg::op_type'(req_tuser);
   assign in_req = req_tdata[20:0];
   assign in_oid = req_tdata[36:21];
   assign accept = req_tvalid && req_tready;

   logic in_bad, ids_out;
   assign in_bad  = (in_req == '0) || (in_req > pool_ff);
   assign ids_out = next_id_ff[ID_BITS];

   logic [FW-1:0] eff_pool;
   assign eff_pool = (pool_ff == '0) ? FW'(1) :
                     (pool_ff > bfsa_pkg::POOL_LIMIT) ? bfsa_pkg::POOL_LIMIT : pool_ff;

   // head of the ring
   logic [FW-1:0]      h_start, h_size;
   logic               h_used, h_valid;
   logic [ID_BITS-1:0] h_id;
   assign h_start = cell_q[0][bfsa_pkg::START_LSB +: FW];
   assign h_size  = cell_q[0][bfsa_pkg::SIZE_LSB +: FW];
   assign h_used  = cell_q[0][bfsa_pkg::USED_BIT];
   assign h_id    = cell_q[0][bfsa_pkg::ID_LSB +: ID_BITS];
   assign h_valid = CNTW'(t_ff) < count_ff;

   logic id_hit;
   assign id_hit = CMPW'(h_id) == CMPW'(oid_ff);

   logic t_last;
   assign t_last = t_ff == LAST_IDX;

   logic [CMPW-1:0] gid_x;
   assign gid_x = CMPW'(next_id_ff[ID_BITS-1:0]);

   // entries built by the sequencer
   logic [ENTW-1:0] init_entry, split_entry, top_entry, compact_entry, alloc_entry;
   logic [IDXW:0]   cq_sum;
   assign init_entry  = {ID_BITS'(0), 1'b0, eff_pool, FW'(0)};
   assign split_entry = {ID_BITS'(0), 1'b0, FW'(b_size_ff - req_ff), FW'(b_start_ff + req_ff)};
   assign top_entry   = {ID_BITS'(0), 1'b0, FW'(total_ff - nxt_ff), nxt_ff};
   assign compact_entry = {h_id, 1'b1, h_size, nxt_ff};
   assign alloc_entry = {next_id_ff[ID_BITS-1:0], 1'b1, req_ff, b_start_ff};
   // compaction write slot: lands at w after the remaining shifts
   assign cq_sum = (IDXW+1)'(w_ff) + (IDXW+1)'(MAX_SEGMENTS - 1) - (IDXW+1)'(t_ff);

   logic [FW-1:0] merged_size;
   assign merged_size = (p_free_ff ? p_size_ff : FW'(0)) + b_size_ff +
                        (n_free_ff ? n_size_ff : FW'(0));

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfsa_pkg::S_BOOT: state_in = bfsa_pkg::S_IDLE;
         bfsa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               case (in_op)
                  bfsa_pkg::OP_ALLOC:
                     state_in = (in_bad || ids_out) ? bfsa_pkg::S_DONE : bfsa_pkg::S_SCAN;
                  bfsa_pkg::OP_INIT: state_in = bfsa_pkg::S_WR;
                  default:           state_in = bfsa_pkg::S_SCAN;
               endcase
            end
         end
         bfsa_pkg::S_SCAN: state_in = t_last ? bfsa_pkg::S_DECIDE : bfsa_pkg::S_SCAN;
         bfsa_pkg::S_DECIDE: begin
            case (op_ff)
               bfsa_pkg::OP_ALLOC: begin
                  if (!found_ff)
                     state_in = bfsa_pkg::S_DONE;
                  else if (b_size_ff > req_ff)
                     state_in = (count_ff == FULL_CNT) ? bfsa_pkg::S_DONE : bfsa_pkg::S_INS;
                  else
                     state_in = bfsa_pkg::S_WR;
               end
               bfsa_pkg::OP_FREE:
                  state_in = found_ff ? bfsa_pkg::S_WR : bfsa_pkg::S_DONE;
               bfsa_pkg::OP_COMPACT:
                  state_in = (nused_ff == FULL_CNT) ? bfsa_pkg::S_DONE : bfsa_pkg::S_COMPACT;
               default: state_in = bfsa_pkg::S_DONE;
            endcase
         end
         bfsa_pkg::S_INS: state_in = bfsa_pkg::S_WR;
         bfsa_pkg::S_WR: begin
            if (op_ff == bfsa_pkg::OP_FREE && n_free_ff)
               state_in = bfsa_pkg::S_REM_A;
            else if (op_ff == bfsa_pkg::OP_FREE && p_free_ff)
               state_in = bfsa_pkg::S_REM_B;
            else
               state_in = bfsa_pkg::S_DONE;
         end
         bfsa_pkg::S_REM_A: state_in = p_free_ff ? bfsa_pkg::S_REM_B : bfsa_pkg::S_DONE;
         bfsa_pkg::S_REM_B: state_in = bfsa_pkg::S_DONE;
         bfsa_pkg::S_COMPACT: state_in = t_last ? bfsa_pkg::S_WR : bfsa_pkg::S_COMPACT;
         bfsa_pkg::S_DONE:
            state_in = (!rsp_valid_ff || rsp_tready) ? bfsa_pkg::S_IDLE : bfsa_pkg::S_DONE;
         default: state_in = bfsa_pkg::S_BOOT;
      endcase
   end

   // ---------------- ring control outputs ----------------
   always_comb begin
      ctl.mode   = bfsa_pkg::SH_HOLD;
      ctl.wr_en  = 1'b0;
      sel_idx    = '0;
      wr_idx     = '0;
      wr_data    = wr_data_ff;
      req_tready = 1'b0;
      case (state_ff)
         bfsa_pkg::S_BOOT: begin
            ctl.wr_en = 1'b1;
            wr_data   = init_entry;
         end
         bfsa_pkg::S_IDLE: req_tready = 1'b1;
         bfsa_pkg::S_SCAN: ctl.mode = bfsa_pkg::SH_LEFT;
         bfsa_pkg::S_INS: begin
            ctl.mode  = bfsa_pkg::SH_INSERT;
            ctl.wr_en = 1'b1;
            sel_idx   = IDXW'(b_idx_ff + 1'b1);
            wr_idx    = IDXW'(b_idx_ff + 1'b1);
            wr_data   = split_entry;
         end
         bfsa_pkg::S_WR: begin
            ctl.wr_en = 1'b1;
            wr_idx    = w_idx_ff;
            wr_data   = (op_ff == bfsa_pkg::OP_COMPACT) ? top_entry : wr_data_ff;
         end
         bfsa_pkg::S_REM_A: begin
            ctl.mode = bfsa_pkg::SH_REMOVE;
            sel_idx  = IDXW'(b_idx_ff + 1'b1);
         end
         bfsa_pkg::S_REM_B: begin
            ctl.mode = bfsa_pkg::SH_REMOVE;
            sel_idx  = b_idx_ff;
         end
         bfsa_pkg::S_COMPACT: begin
            ctl.mode  = bfsa_pkg::SH_LEFT;
            ctl.wr_en = h_valid && h_used;
            wr_idx    = cq_sum[IDXW-1:0];
            wr_data   = compact_entry;
         end
         default: ;
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfsa_pkg::S_BOOT;
         pool_ff      <= bfsa_pkg::POOL_RESET;
         count_ff     <= CNTW'(1);
         next_id_ff   <= (ID_BITS+1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) pool_ff <= csr_wr_data;
         if (state_ff == bfsa_pkg::S_DONE && state_in == bfsa_pkg::S_IDLE)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            bfsa_pkg::S_IDLE: begin
               if (accept && in_op == bfsa_pkg::OP_INIT) begin
                  count_ff   <= CNTW'(1);
                  next_id_ff <= (ID_BITS+1)'(1);
               end
            end
            bfsa_pkg::S_INS: count_ff <= count_ff + 1'b1;
            bfsa_pkg::S_REM_A, bfsa_pkg::S_REM_B: count_ff <= count_ff - 1'b1;
            bfsa_pkg::S_WR: begin
               if (op_ff == bfsa_pkg::OP_COMPACT) count_ff <= w_ff + 1'b1;
               if (op_ff == bfsa_pkg::OP_ALLOC) next_id_ff <= next_id_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // ---------------- sequencer datapath ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         bfsa_pkg::S_IDLE: begin
            if (accept) begin
               op_ff         <= in_op;
               req_ff        <= in_req;
               oid_ff        <= in_oid;
               t_ff          <= '0;
               found_ff      <= 1'b0;
               p_free_ff     <= 1'b0;
               n_free_ff     <= 1'b0;
               after_ff      <= 1'b0;
               total_ff      <= '0;
               nused_ff      <= '0;
               nxt_ff        <= '0;
               w_ff          <= '0;
               w_idx_ff      <= '0;
               wr_data_ff    <= init_entry;
               res_gid_ff    <= '0;
               res_start_ff  <= '0;
               res_size_ff   <= (in_op == bfsa_pkg::OP_INIT) ? eff_pool : '0;
               if (in_op == bfsa_pkg::OP_ALLOC && in_bad)
                  res_status_ff <= bfsa_pkg::ST_BAD_SIZE;
               else if (in_op == bfsa_pkg::OP_ALLOC && ids_out)
                  res_status_ff <= bfsa_pkg::ST_IDS_EXHAUSTED;
               else
                  res_status_ff <= bfsa_pkg::ST_OK;
            end
         end
         bfsa_pkg::S_SCAN: begin
            t_ff          <= t_ff + 1'b1;
            prev_used_ff  <= h_used;
            prev_start_ff <= h_start;
            prev_size_ff  <= h_size;
            case (op_ff)
               bfsa_pkg::OP_ALLOC: begin
                  // smallest fit, first one wins a tie
                  if (h_valid && !h_used && h_size >= req_ff &&
                      (!found_ff || h_size < b_size_ff)) begin
                     found_ff   <= 1'b1;
                     b_idx_ff   <= t_ff;
                     b_start_ff <= h_start;
                     b_size_ff  <= h_size;
                  end
               end
               bfsa_pkg::OP_FREE: begin
                  // marks the cycle right after the match
                  after_ff <= h_valid && !found_ff && h_used && id_hit;
                  if (h_valid && !found_ff && h_used && id_hit) begin
                     found_ff   <= 1'b1;
                     b_idx_ff   <= t_ff;
                     b_start_ff <= h_start;
                     b_size_ff  <= h_size;
                     p_free_ff  <= (t_ff != '0) && !prev_used_ff;
                     p_start_ff <= prev_start_ff;
                     p_size_ff  <= prev_size_ff;
                  end
                  // upper neighbor of the match
                  if (after_ff && h_valid) begin
                     n_free_ff <= !h_used;
                     n_size_ff <= h_size;
                  end
               end
               bfsa_pkg::OP_COMPACT: begin
                  if (h_valid) begin
                     total_ff <= total_ff + h_size;
                     if (h_used) nused_ff <= nused_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         bfsa_pkg::S_DECIDE: begin
            t_ff <= '0;
            case (op_ff)
               bfsa_pkg::OP_ALLOC: begin
                  if (!found_ff) begin
                     res_status_ff <= bfsa_pkg::ST_NO_FIT;
                  end else if (b_size_ff > req_ff && count_ff == FULL_CNT) begin
                     res_status_ff <= bfsa_pkg::ST_TABLE_FULL;
                  end else begin
                     w_idx_ff     <= b_idx_ff;
                     wr_data_ff   <= alloc_entry;
                     res_gid_ff   <= gid_x[15:0];
                     res_start_ff <= b_start_ff;
                     res_size_ff  <= req_ff;
                  end
               end
               bfsa_pkg::OP_FREE: begin
                  if (!found_ff) begin
                     res_status_ff <= bfsa_pkg::ST_UNKNOWN_ID;
                  end else begin
                     w_idx_ff     <= p_free_ff ? IDXW'(b_idx_ff - 1'b1) : b_idx_ff;
                     wr_data_ff   <= {ID_BITS'(0), 1'b0, merged_size,
                                      p_free_ff ? p_start_ff : b_start_ff};
                     res_start_ff <= p_free_ff ? p_start_ff : b_start_ff;
                     res_size_ff  <= merged_size;
                  end
               end
               bfsa_pkg::OP_COMPACT: begin
                  if (nused_ff == FULL_CNT) res_status_ff <= bfsa_pkg::ST_TABLE_FULL;
               end
               default: ;
            endcase
         end
         bfsa_pkg::S_COMPACT: begin
            t_ff <= t_ff + 1'b1;
            if (h_valid && h_used) begin
               nxt_ff <= nxt_ff + h_size;
               w_ff   <= w_ff + 1'b1;
            end
            if (t_last) w_idx_ff <= IDXW'(w_ff + CNTW'(h_valid && h_used));
         end
         bfsa_pkg::S_WR: begin
            if (op_ff == bfsa_pkg::OP_COMPACT) begin
               res_start_ff <= nxt_ff;
               res_size_ff  <= total_ff - nxt_ff;
            end
         end
         bfsa_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_status_ff <= res_status_ff;
               rsp_gid_ff    <= res_gid_ff;
               rsp_start_ff  <= res_start_ff;
               rsp_size_ff   <= res_size_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_size_ff, rsp_start_ff, rsp_gid_ff};

   // ---------------- assertions ----------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= FULL_CNT)
      else $error("segment count out of range");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfsa_pkg::S_INS |-> count_ff < FULL_CNT)
      else $error("split insert into a full table");

   a_alloc_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfsa_pkg::S_WR && op_ff == bfsa_pkg::OP_ALLOC |-> found_ff)
      else $error("allocate write without a fitting segment");

   a_used_le_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfsa_pkg::S_DECIDE && op_ff == bfsa_pkg::OP_COMPACT
      |-> nused_ff <= count_ff)
      else $error("more used segments than entries");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != bfsa_pkg::ST_OK
      |-> rsp_gid_ff == '0 && rsp_start_ff == '0 && rsp_size_ff == '0)
      else $error("error result carries nonzero payload");

endmodule
`default_nettype wire
